FILE: src/tfcl_pkg.sv
// shared types and constants for the tcp flow context lookup
// no dependencies
`default_nettype none
package tfcl_pkg;
    localparam logic [15:0] PROFILE_TCP = 16'd6;
    localparam logic [7:0]  PROTO_TCP   = 8'd6;
    localparam logic [31:0] LCG_MUL     = 32'd1664525;
    localparam logic [31:0] LCG_ADD     = 32'd1013904223;
    localparam logic [31:0] SEED_RESET  = 32'd12345;

    // flow key compared in every cell
    typedef struct packed {
        logic [15:0] profile;
        logic [31:0] src;
        logic [31:0] dst;
        logic [7:0]  proto;
        logic [15:0] pfrom;
        logic [15:0] pto;
    } flow_key_t;

    // command broadcast to the cells
    typedef struct packed {
        logic        refresh;
        logic        fill;
        logic [31:0] now;
    } cell_cmd_t;
endpackage
`default_nettype wire

FILE: src/tfcl_cell.sv
// one flow context cell: holds one entry, compares it, and passes the
// running oldest-entry search on to its neighbor; uses tfcl_pkg
`default_nettype none
module tfcl_cell
    import tfcl_pkg::*;
#(
    parameter int IDX_W = 4,
    parameter logic [IDX_W-1:0] INDEX = '0
)
(
    input  wire              clk,
    input  wire              rst_n,
    input  flow_key_t        key,
    input  cell_cmd_t        cmd,
    input  wire [IDX_W-1:0]  target,
    input  wire              age_in_valid,
    input  wire [31:0]       age_in,
    input  wire [IDX_W-1:0]  age_idx_in,
    output logic             age_out_valid,
    output logic [31:0]      age_out,
    output logic [IDX_W-1:0] age_idx_out,
    output logic             match,
    output logic             used
);
    logic        used_reg;
    flow_key_t   key_reg;
    logic [31:0] seen_reg;
    logic        sel;

    assign sel   = (target == INDEX);
    assign used  = used_reg;
    assign match = used_reg && (key_reg == key);

    // entry storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else if (sel && cmd.fill)
        begin
            used_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel && cmd.fill)
        begin
            key_reg <= key;
        end
        if (sel && (cmd.fill || cmd.refresh))
        begin
            seen_reg <= cmd.now;
        end
    end

    // running minimum; strict less keeps the lowest index on ties
    always_comb
    begin
        if (!age_in_valid || (seen_reg < age_in))
        begin
            age_out_valid = 1'b1;
            age_out       = seen_reg;
            age_idx_out   = INDEX;
        end
        else
        begin
            age_out_valid = 1'b1;
            age_out       = age_in;
            age_idx_out   = age_idx_in;
        end
    end
endmodule
`default_nettype wire

FILE: src/tfcl_age_chain.sv
// row of cells with a registered oldest-entry search every few cells
// uses tfcl_pkg and tfcl_cell
`default_nettype none
module tfcl_age_chain
    import tfcl_pkg::*;
#(
    parameter int SLOTS = 16,
    parameter int IDX_W = 4,
    parameter int SEG   = 4
)
(
    input  wire              clk,
    input  wire              rst_n,
    input  flow_key_t        key,
    input  cell_cmd_t        cmd,
    input  wire [IDX_W-1:0]  target,
    output logic [SLOTS-1:0] match,
    output logic [SLOTS-1:0] used,
    output logic [IDX_W-1:0] oldest
);
    localparam int NSEG = (SLOTS + SEG - 1) / SEG;

    logic [SLOTS-1:0]     av;
    logic [31:0]          ag  [SLOTS];
    logic [IDX_W-1:0]     ai  [SLOTS];
    logic [SLOTS:0]       cv;
    logic [31:0]          cg  [SLOTS+1];
    logic [IDX_W-1:0]     ci  [SLOTS+1];
    logic [NSEG-1:0]      v_reg;
    logic [31:0]          g_reg [NSEG];
    logic [IDX_W-1:0]     i_reg [NSEG];

    assign cv[0] = 1'b0;
    assign cg[0] = '0;
    assign ci[0] = '0;

    for (genvar k = 0; k < SLOTS; k++)
    begin : g_cell
        if (k % SEG == 0 && k != 0)
        begin : g_cut
            assign av[k] = v_reg[k/SEG - 1];
            assign ag[k] = g_reg[k/SEG - 1];
            assign ai[k] = i_reg[k/SEG - 1];
        end
        else
        begin : g_pass
            assign av[k] = cv[k];
            assign ag[k] = cg[k];
            assign ai[k] = ci[k];
        end
        tfcl_cell #(.IDX_W(IDX_W), .INDEX(IDX_W'(k))) u_cell (
            .clk(clk), .rst_n(rst_n), .key(key), .cmd(cmd), .target(target),
            .age_in_valid(av[k]), .age_in(ag[k]), .age_idx_in(ai[k]),
            .age_out_valid(cv[k+1]), .age_out(cg[k+1]), .age_idx_out(ci[k+1]),
            .match(match[k]), .used(used[k])
        );
    end

    // segment boundary registers, one hop of the search per cycle
    for (genvar s = 0; s < NSEG; s++)
    begin : g_seg
        localparam int LAST = ((s + 1) * SEG < SLOTS) ? (s + 1) * SEG : SLOTS;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else
            begin
                v_reg[s] <= cv[LAST];
            end
        end
        always_ff @(posedge clk)
        begin
            g_reg[s] <= cg[LAST];
            i_reg[s] <= ci[LAST];
        end
    end

    assign oldest = i_reg[NSEG-1];
endmodule
`default_nettype wire

FILE: src/tcp_flow_context_lookup.sv
// top level of the tcp flow context lookup: header check, control sequencer
// uses tfcl_pkg and tfcl_age_chain
// a lookup goes from the look state to the result; on eviction it passes through the age state first,
// where the registered oldest-entry search hops one group of 4 cells a cycle
// one item at a time: the input stalls until the result transfer, and output stalls hold the result
// reset clears all used marks and the fill count and loads the generator seed
`default_nettype none
module tcp_flow_context_lookup
    import tfcl_pkg::*;
#(
    parameter int FLOW_SLOTS = 16
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire [63:0]  ip_head_bytes_0_to_7,
    input  wire [63:0]  ip_head_bytes_8_to_15,
    input  wire [31:0]  ip_destination,
    input  wire [15:0]  port_from,
    input  wire [15:0]  port_to,
    input  wire [3:0]   tcp_header_words,
    input  wire [31:0]  arrival_second,
    input  wire         hint_given,
    input  wire [15:0]  profile_hint,
    output logic        out_valid,
    input  wire         out_stall,
    output logic        rejected,
    output logic [3:0]  flow_slot,
    output logic        hit,
    output logic        evicted,
    output logic [15:0] start_sequence
);
    localparam int IDX_W = $clog2(FLOW_SLOTS);
    localparam int SEG   = 4;
    localparam int NSEG  = (FLOW_SLOTS + SEG - 1) / SEG;
    localparam int CNT_W = $clog2(NSEG + 1);
    localparam int USE_W = $clog2(FLOW_SLOTS + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_LOOK, ST_AGE, ST_OUT} state_t;

    state_t          state_reg;
    flow_key_t       key_reg;
    logic [31:0]     now_reg;
    logic            ok_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [USE_W-1:0] used_cnt_reg;
    logic [31:0]     seed_reg;
    logic [31:0]     seed_next;
    logic [IDX_W-1:0] target;
    cell_cmd_t       cmd;
    logic [FLOW_SLOTS-1:0] match, used;
    logic [IDX_W-1:0] oldest, hit_idx, free_idx;
    logic            any_hit;
    logic            hdr_ok;
    logic [19:0]     sum;
    logic [16:0]     f1;
    logic [15:0]     f2;

    // header checks
    always_comb
    begin
        sum = 20'(ip_head_bytes_0_to_7[63:48]) + 20'(ip_head_bytes_0_to_7[47:32])
            + 20'(ip_head_bytes_0_to_7[31:16]) + 20'(ip_head_bytes_0_to_7[15:0])
            + 20'(ip_head_bytes_8_to_15[63:48]) + 20'(ip_head_bytes_8_to_15[47:32])
            + 20'(ip_head_bytes_8_to_15[31:16]) + 20'(ip_head_bytes_8_to_15[15:0])
            + 20'(ip_destination[31:16]) + 20'(ip_destination[15:0]);
        f1 = 17'(sum[15:0]) + 17'(sum[19:16]);
        f2 = f1[15:0] + 16'(f1[16]);
        hdr_ok = (ip_head_bytes_0_to_7[59:56] == 4'd5)
              && ((ip_head_bytes_0_to_7[15:0] & 16'hbfff) == 16'd0)
              && (f2 == 16'hffff)
              && (ip_head_bytes_8_to_15[55:48] == PROTO_TCP)
              && (tcp_header_words >= 4'd5);
    end

    // priority encoders over match and free lines
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        any_hit  = |match;
        for (int k = FLOW_SLOTS - 1; k >= 0; k--)
        begin
            if (match[k])
            begin
                hit_idx = IDX_W'(k);
            end
            if (!used[k])
            begin
                free_idx = IDX_W'(k);
            end
        end
    end

    logic full;
    assign full = (used_cnt_reg == USE_W'(FLOW_SLOTS));
    assign seed_next = seed_reg * LCG_MUL + LCG_ADD;

    // command to the cells in the look and age states
    always_comb
    begin
        cmd.now     = now_reg;
        cmd.refresh = 1'b0;
        cmd.fill    = 1'b0;
        target      = any_hit ? hit_idx : free_idx;
        if (state_reg == ST_LOOK && ok_reg)
        begin
            cmd.refresh = any_hit;
            cmd.fill    = !any_hit && !full;
        end
        else if (state_reg == ST_AGE && cnt_reg == '0)
        begin
            cmd.fill = 1'b1;
            target   = oldest;
        end
    end

    tfcl_age_chain #(.SLOTS(FLOW_SLOTS), .IDX_W(IDX_W), .SEG(SEG)) u_chain (
        .clk(clk), .rst_n(rst_n), .key(key_reg), .cmd(cmd), .target(target),
        .match(match), .used(used), .oldest(oldest)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    // sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            used_cnt_reg   <= '0;
            seed_reg       <= SEED_RESET;
            cnt_reg        <= '0;
            rejected       <= 1'b0;
            flow_slot      <= '0;
            hit            <= 1'b0;
            evicted        <= 1'b0;
            start_sequence <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_LOOK;
                    end
                end
                ST_LOOK:
                begin
                    rejected       <= !ok_reg;
                    flow_slot      <= '0;
                    hit            <= 1'b0;
                    evicted        <= 1'b0;
                    start_sequence <= '0;
                    if (!ok_reg)
                    begin
                        state_reg <= ST_OUT;
                    end
                    else if (any_hit)
                    begin
                        flow_slot <= 4'(hit_idx);
                        hit       <= 1'b1;
                        state_reg <= ST_OUT;
                    end
                    else if (!full)
                    begin
                        flow_slot      <= 4'(free_idx);
                        seed_reg       <= seed_next;
                        start_sequence <= seed_next[15:0];
                        used_cnt_reg   <= used_cnt_reg + 1'b1;
                        state_reg      <= ST_OUT;
                    end
                    else
                    begin
                        cnt_reg   <= CNT_W'(NSEG - 1);
                        state_reg <= ST_AGE;
                    end
                end
                ST_AGE:
                begin
                    if (cnt_reg == '0)
                    begin
                        flow_slot      <= 4'(oldest);
                        evicted        <= 1'b1;
                        seed_reg       <= seed_next;
                        start_sequence <= seed_next[15:0];
                        state_reg      <= ST_OUT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_OUT:
                begin
                    if (!out_stall)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // captured item
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            key_reg.profile <= hint_given ? profile_hint : PROFILE_TCP;
            key_reg.src     <= ip_head_bytes_8_to_15[31:0];
            key_reg.dst     <= ip_destination;
            key_reg.proto   <= ip_head_bytes_8_to_15[55:48];
            key_reg.pfrom   <= port_from;
            key_reg.pto     <= port_to;
            now_reg         <= arrival_second;
            ok_reg          <= hint_given || hdr_ok;
        end
    end

`ifndef SYNTHESIS
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        used_cnt_reg == USE_W'($countones(used)))
        else $error("fill count differs from used marks");
    a_hit_one: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match))
        else $error("more than one entry matched");
    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_AGE) |-> full)
        else $error("eviction while table not full");
`endif
endmodule
`default_nettype wire

FILE: tb/tfcl_checker.sv
// result checker for the tcp flow context lookup: watches both channels,
// predicts each result from its own copy of the flow table, compares fields
// depends on tfcl_pkg
`timescale 1ns / 100ps
module tfcl_checker
    import tfcl_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    input  wire         in_stall,
    input  wire [63:0]  ip_head_bytes_0_to_7,
    input  wire [63:0]  ip_head_bytes_8_to_15,
    input  wire [31:0]  ip_destination,
    input  wire [15:0]  port_from,
    input  wire [15:0]  port_to,
    input  wire [3:0]   tcp_header_words,
    input  wire [31:0]  arrival_second,
    input  wire         hint_given,
    input  wire [15:0]  profile_hint,
    input  wire         out_valid,
    input  wire         out_stall,
    input  wire         rejected,
    input  wire [3:0]   flow_slot,
    input  wire         hit,
    input  wire         evicted,
    input  wire [15:0]  start_sequence,
    output int          fail_count,
    output int          pending_lookups,
    output int          hit_total,
    output int          evict_total,
    output int          reject_total
);
    localparam int SLOTS = 16;

    typedef struct packed {
        logic        rejected;
        logic [3:0]  slot;
        logic        hit;
        logic        evicted;
        logic [15:0] start_seq;
    } lookup_result_t;

    logic        flow_used [SLOTS];
    flow_key_t   flow_key [SLOTS];
    logic [31:0] flow_seen [SLOTS];
    int          flows_held;
    logic [31:0] seq_seed;
    lookup_result_t expected_lookups [$];

    assign pending_lookups = expected_lookups.size();

    // ones-complement header checks, no hint
    function automatic logic header_valid(logic [63:0] w0, logic [63:0] w1,
                                          logic [31:0] dst, logic [3:0] words);
        logic [31:0] sum;
        sum = 0;
        if (w0[59:56] != 4'd5) return 1'b0;
        if ((w0[15:0] & 16'hbfff) != 16'd0) return 1'b0;
        for (int k = 0; k < 4; k++)
            sum += w0[16*k +: 16] + w1[16*k +: 16];
        sum += dst[15:0] + dst[31:16];
        sum = sum[15:0] + sum[31:16];
        sum = sum[15:0] + sum[31:16];
        if (sum != 32'h0000ffff) return 1'b0;
        if (w1[55:48] != PROTO_TCP) return 1'b0;
        return words >= 4'd5;
    endfunction

    // predict one lookup and update the table copy
    function automatic lookup_result_t predict_lookup();
        lookup_result_t r;
        flow_key_t key;
        int slot;
        logic [31:0] oldest;
        r = '0;
        slot = -1;
        if (!hint_given && !header_valid(ip_head_bytes_0_to_7, ip_head_bytes_8_to_15,
                                         ip_destination, tcp_header_words))
        begin
            r.rejected = 1'b1;
            return r;
        end
        key.profile = hint_given ? profile_hint : PROFILE_TCP;
        key.src = ip_head_bytes_8_to_15[31:0];
        key.dst = ip_destination;
        key.proto = ip_head_bytes_8_to_15[55:48];
        key.pfrom = port_from;
        key.pto = port_to;
        for (int k = 0; k < SLOTS; k++)
            if (slot < 0 && flow_used[k] && flow_key[k] == key) slot = k;
        if (slot >= 0)
        begin
            flow_seen[slot] = arrival_second;
            r.slot = slot[3:0];
            r.hit = 1'b1;
            return r;
        end
        if (flows_held >= SLOTS)
        begin
            slot = 0;
            oldest = flow_seen[0];
            for (int k = 1; k < SLOTS; k++)
                if (flow_seen[k] < oldest)
                begin
                    oldest = flow_seen[k];
                    slot = k;
                end
            r.evicted = 1'b1;
        end
        else
        begin
            slot = 0;
            for (int k = SLOTS - 1; k >= 0; k--)
                if (!flow_used[k]) slot = k;
            flows_held++;
        end
        seq_seed = seq_seed * LCG_MUL + LCG_ADD;
        flow_key[slot] = key;
        flow_seen[slot] = arrival_second;
        flow_used[slot] = 1'b1;
        r.slot = slot[3:0];
        r.start_seq = seq_seed[15:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // collect transfers and compare
    always @(posedge clk or negedge rst_n)
    begin
        lookup_result_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < SLOTS; k++) flow_used[k] = 1'b0;
            flows_held = 0;
            seq_seed = SEED_RESET;
            expected_lookups.delete();
            fail_count = 0;
            hit_total = 0;
            evict_total = 0;
            reject_total = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_lookups.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected", $realtime);
                    fail_count++;
                end
                else
                begin
                    want = expected_lookups.pop_front();
                    if (rejected !== want.rejected)
                        report_mismatch("rejected", rejected, want.rejected);
                    if (flow_slot !== want.slot)
                        report_mismatch("flow_slot", flow_slot, want.slot);
                    if (hit !== want.hit) report_mismatch("hit", hit, want.hit);
                    if (evicted !== want.evicted)
                        report_mismatch("evicted", evicted, want.evicted);
                    if (start_sequence !== want.start_seq)
                        report_mismatch("start_sequence", start_sequence, want.start_seq);
                end
            end
            if (in_valid && !in_stall)
            begin
                want = predict_lookup();
                hit_total += want.hit;
                evict_total += want.evicted;
                reject_total += want.rejected;
                expected_lookups.push_back(want);
            end
        end
    end
endmodule

FILE: tb/tb_top.sv
// stimulus and verdict for the tcp flow context lookup
// depends on tfcl_pkg, tcp_flow_context_lookup and tfcl_checker
`timescale 1ns / 100ps
module tb_top;
    import tfcl_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        out_stall = 1'b0;
    logic [63:0] ip_head_bytes_0_to_7 = '0;
    logic [63:0] ip_head_bytes_8_to_15 = '0;
    logic [31:0] ip_destination = '0;
    logic [15:0] port_from = '0;
    logic [15:0] port_to = '0;
    logic [3:0]  tcp_header_words = '0;
    logic [31:0] arrival_second = '0;
    logic        hint_given = 1'b0;
    logic [15:0] profile_hint = '0;
    wire         in_stall, out_valid, rejected, hit, evicted;
    wire [3:0]   flow_slot;
    wire [15:0]  start_sequence;
    int          fail_count, pending_lookups, hit_total, evict_total, reject_total;
    int          idle_cycles = 0;
    int          sent = 0;
    logic [31:0] clock_now = 32'd100;

    // pools of recurring flows, so that hits and evictions happen often
    logic [31:0] addr_pool [8];
    logic [15:0] port_pool [8];

    always #6 clk = ~clk;

    tcp_flow_context_lookup i_dut (.*);
    tfcl_checker i_checker (.*);

    // receiver stall pattern with calm stretches
    always @(posedge clk)
    begin
        int phase;
        phase = (sent / 100) % 3;
        if (phase == 0) out_stall <= 1'b0;
        else if (phase == 1) out_stall <= ($urandom_range(0, 3) == 0);
        else out_stall <= ($urandom_range(0, 9) < 6);
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tcp_flow_context_lookup: mismatch");
            $finish;
        end
    end

    // fix the checksum so the header folds to all ones
    function automatic logic [63:0] seal_checksum(logic [63:0] w0, logic [63:0] w1,
                                                  logic [31:0] dst);
        logic [31:0] sum;
        sum = 0;
        w1[47:32] = 16'd0;
        for (int k = 0; k < 4; k++)
            sum += w0[16*k +: 16] + w1[16*k +: 16];
        sum += dst[15:0] + dst[31:16];
        sum = sum[15:0] + sum[31:16];
        sum = sum[15:0] + sum[31:16];
        w1[47:32] = ~sum[15:0];
        return w1;
    endfunction

    // one transfer on the input channel
    task automatic send_packet(logic [63:0] w0, logic [63:0] w1, logic [31:0] dst,
                               logic [15:0] pf, logic [15:0] pt, logic [3:0] words,
                               logic [31:0] tsec, logic hinted, logic [15:0] prof);
        in_valid <= 1'b1;
        ip_head_bytes_0_to_7 <= w0;
        ip_head_bytes_8_to_15 <= w1;
        ip_destination <= dst;
        port_from <= pf;
        port_to <= pt;
        tcp_header_words <= words;
        arrival_second <= tsec;
        hint_given <= hinted;
        profile_hint <= prof;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    task automatic pause_sender(int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // a well-formed tcp packet with optional corruption
    task automatic send_flow(logic [31:0] src, logic [31:0] dst, logic [15:0] pf,
                             logic [15:0] pt, logic [31:0] tsec, int damage);
        logic [63:0] w0, w1;
        logic [3:0] words;
        w0 = {4'd4, 4'd5, 8'($urandom), 16'($urandom), 16'($urandom),
              ($urandom_range(0, 1) ? 16'h4000 : 16'h0000)};
        w1 = {8'($urandom), PROTO_TCP, 16'd0, src};
        words = 4'($urandom_range(5, 15));
        case (damage)
            1: w0[59:56] = 4'($urandom_range(0, 15)) | 4'd8;
            2: w0[15:0] = w0[15:0] | (16'd1 << $urandom_range(0, 13));
            3: w1[55:48] = 8'($urandom_range(7, 255));
            4: words = 4'($urandom_range(0, 4));
            default: ;
        endcase
        w1 = seal_checksum(w0, w1, dst);
        if (damage == 5) w1[47:32] = w1[47:32] ^ (16'd1 << $urandom_range(0, 15));
        if (damage == 6) w0[15] = 1'b1;
        send_packet(w0, w1, dst, pf, pt, words, tsec, 1'b0, 16'd0);
    endtask

    initial
    begin
        int burst;
        int pick;
        logic [31:0] tsec;
        for (int k = 0; k < 8; k++)
        begin
            addr_pool[k] = $urandom;
            port_pool[k] = 16'($urandom);
        end
        addr_pool[0] = 32'hffffffff;
        port_pool[0] = 16'hffff;
        port_pool[1] = 16'h0000;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: header checks, hints, extremes
        send_packet('0, '0, '0, '0, '0, '0, '0, 1'b0, '0);
        send_packet('1, '1, '1, '1, '1, '1, '1, 1'b0, '1);
        send_packet('1, '1, '1, '1, '1, '1, '1, 1'b1, '1);
        send_packet('0, '0, '0, '0, '0, '0, '0, 1'b1, '0);
        send_packet('0, '0, '0, '0, '0, '0, 32'd5, 1'b1, '0);
        send_packet('0, '0, '0, '0, '0, '0, '1, 1'b1, 16'd6);
        for (int d = 0; d <= 6; d++)
            send_flow(addr_pool[0], addr_pool[1], port_pool[0], port_pool[1], 32'd7, d);
        send_flow(addr_pool[0], addr_pool[1], port_pool[0], port_pool[1], 32'd8, 0);
        // fill the remaining slots with equal ages, then force an eviction tie
        for (int k = 0; k < 12; k++)
            send_flow(32'd1000 + k, 32'hffffffff, 16'd80, 16'(k), 32'd0, 0);
        send_flow(32'd5000, 32'd1, 16'd1, 16'd2, 32'hffffffff, 0);

        // wait for every result before going random
        pause_sender(1);
        while (pending_lookups != 0) @(posedge clk);

        // random: mostly recurring flows, some noise and broken headers
        while (sent < 620)
        begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst; b++)
            begin
                pick = $urandom_range(0, 99);
                tsec = ($urandom_range(0, 9) == 0) ? $urandom : clock_now;
                clock_now += $urandom_range(0, 3);
                if (pick < 60)
                    send_flow(addr_pool[$urandom_range(0, 4)], addr_pool[$urandom_range(0, 4)],
                              port_pool[$urandom_range(0, 3)], port_pool[$urandom_range(0, 3)],
                              tsec, 0);
                else if (pick < 70)
                    send_flow($urandom, $urandom, 16'($urandom), 16'($urandom), tsec, 0);
                else if (pick < 82)
                    send_packet({$urandom, $urandom}, {$urandom, $urandom},
                                addr_pool[$urandom_range(0, 7)], port_pool[$urandom_range(0, 7)],
                                port_pool[$urandom_range(0, 7)], 4'($urandom), tsec, 1'b1,
                                16'($urandom_range(0, 3) == 0 ? $urandom : 6));
                else if (pick < 94)
                    send_flow(addr_pool[$urandom_range(0, 7)], addr_pool[$urandom_range(0, 7)],
                              port_pool[$urandom_range(0, 7)], port_pool[$urandom_range(0, 7)],
                              tsec, $urandom_range(1, 6));
                else
                    send_packet({$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                                16'($urandom), 16'($urandom), 4'($urandom), $urandom,
                                1'b0, 16'($urandom));
            end
            if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 15));
        end
        in_valid <= 1'b0;

        // drain and settle
        while (pending_lookups != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("sent %0d packets: %0d hits, %0d evictions, %0d rejected", sent,
                 hit_total, evict_total, reject_total);
        if (fail_count == 0)
            $display("tcp_flow_context_lookup: match");
        else
            $display("tcp_flow_context_lookup: mismatch");
        $finish;
    end
endmodule
